// ===== rtl/core/mnd_pkg.sv =====
package mnd_pkg;

  localparam int SLOT_REGS       = 4;
  localparam int MAX_INSTRUMENTS = 4;
  localparam int SLOT_W          = 2;
  localparam int CNT_W           = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 26;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INST0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INST3 = 3'd4;

  // MIDI codes
  localparam logic [7:0] MIDI_CLOCK    = 8'hF8;
  localparam logic [7:0] STATUS_LO     = 8'h80;
  localparam logic [7:0] STATUS_HI     = 8'hEF;
  localparam logic [3:0] CMD_NOTE_OFF  = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON   = 4'h9;
  localparam logic [3:0] CMD_BEND      = 4'hE;
  localparam logic [15:0] BEND_CENTRE  = 16'd8192;

  typedef enum logic [1:0] {
    EV_PLAY = 2'd0,
    EV_STOP = 2'd1,
    EV_BEND = 2'd2,
    EV_TICK = 2'd3
  } ev_kind_t;

  typedef enum logic [1:0] {
    PS_IDLE  = 2'd0,
    PS_DATA1 = 2'd1,
    PS_DATA2 = 2'd2
  } parse_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } ctl_state_t;

  typedef struct packed {
    logic accept;
    logic emit;
  } mnd_cmd_t;

  typedef struct packed {
    logic new_nz;
    logic last_one;
    logic out_valid;
  } mnd_sts_t;

endpackage

// ===== rtl/core/mnd_ctrl.sv =====
module mnd_ctrl
  import mnd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     out_stall,
  input  mnd_sts_t sts,
  output mnd_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept && sts.new_nz) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.emit && sts.last_one) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cmd.accept = 1'b0;
    cmd.emit   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_EMIT: begin
        // load the output register once it is free or being drained
        cmd.emit = !sts.out_valid || !out_stall;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/mnd_datapath.sv =====
module mnd_datapath
  import mnd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]            in_midi_byte,
  input  logic                  out_stall,
  input  mnd_cmd_t              cmd,
  output mnd_sts_t              sts,
  output logic                  out_valid,
  output logic [SLOT_W-1:0]     out_slot,
  output logic [1:0]            out_event_kind,
  output logic signed [9:0]     out_note_out,
  output logic [7:0]            out_velocity_out,
  output logic signed [15:0]    out_bend_offset,
  output logic                  out_last
);

  localparam int CAP = (MAX_INSTRUMENTS < SLOT_REGS) ? MAX_INSTRUMENTS : SLOT_REGS;

  logic [CNT_W-1:0]      cnt_r;
  logic [CFG_DATA_W-1:0] inst_r [SLOT_REGS];
  logic [CFG_IDX_W-1:0]  idx_m1;

  parse_t     parse_r, parse_nxt;
  logic [3:0] chan_r, chan_nxt;
  logic [3:0] cmd_r, cmd_nxt;
  logic [7:0] note_r, note_nxt;

  logic [SLOT_REGS-1:0] pend_r, pend_nxt;
  logic [SLOT_REGS-1:0] active, chan_hit, range_hit, new_mask, sel_bit;
  ev_kind_t             new_kind;
  logic [SLOT_W-1:0]    sel;
  logic [CNT_W-1:0]     n_eff;
  logic [15:0]          bend_raw;

  ev_kind_t          ev_kind_r;
  logic [7:0]        ev_note_r;
  logic [7:0]        ev_vel_r;
  logic [15:0]       ev_bend_r;

  logic              out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] out_slot_r;
  ev_kind_t          out_kind_r;
  logic [9:0]        out_note_r, note_sum;
  logic [7:0]        out_vel_r;
  logic [15:0]       out_bend_r;
  logic              out_last_r, last_nxt;
  logic [7:0]        tr;

  assign idx_m1 = cfg_index - CFG_INST0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      for (int i = 0; i < SLOT_REGS; i++) inst_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COUNT: cnt_r <= cfg_data[CNT_W-1:0];
        default: begin
          if (cfg_index inside {[CFG_INST0:CFG_INST3]}) inst_r[idx_m1[SLOT_W-1:0]] <= cfg_data;
        end
      endcase
    end
  end

  assign n_eff = (cnt_r > CNT_W'(CAP)) ? CNT_W'(CAP) : cnt_r;

  always_comb begin
    for (int i = 0; i < SLOT_REGS; i++) begin
      active[i]    = CNT_W'(i) < n_eff;
      chan_hit[i]  = inst_r[i][3:0] == chan_r;
      range_hit[i] = (note_r >= {1'b0, inst_r[i][10:4]}) &&
                     (note_r <= {1'b0, inst_r[i][17:11]});
    end
  end

  assign bend_raw = ({1'b0, in_midi_byte, 7'b0} | {8'b0, note_r}) - BEND_CENTRE;

  // parse step and event mask for the byte on the input
  always_comb begin
    parse_nxt = parse_r;
    chan_nxt  = chan_r;
    cmd_nxt   = cmd_r;
    note_nxt  = note_r;
    new_mask  = '0;
    new_kind  = EV_TICK;
    if (in_midi_byte == MIDI_CLOCK) begin
      new_mask = active;
    end else begin
      case (parse_r)
        PS_DATA1: begin
          note_nxt  = in_midi_byte;
          parse_nxt = PS_DATA2;
        end
        PS_DATA2: begin
          parse_nxt = PS_IDLE;
          if (cmd_r == CMD_NOTE_OFF || cmd_r == CMD_NOTE_ON) begin
            new_mask = active & chan_hit & range_hit;
            new_kind = (cmd_r == CMD_NOTE_OFF || in_midi_byte == 8'd0) ? EV_STOP : EV_PLAY;
          end else if (cmd_r == CMD_BEND) begin
            new_mask = active & chan_hit;
            new_kind = EV_BEND;
          end
        end
        default: begin
          if (in_midi_byte inside {[STATUS_LO:STATUS_HI]}) begin
            chan_nxt  = in_midi_byte[3:0];
            cmd_nxt   = in_midi_byte[7:4];
            parse_nxt = PS_DATA1;
          end else begin
            parse_nxt = PS_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parse_r <= PS_IDLE;
      chan_r  <= '0;
      cmd_r   <= '0;
      note_r  <= '0;
    end else if (cmd.accept) begin
      parse_r <= parse_nxt;
      chan_r  <= chan_nxt;
      cmd_r   <= cmd_nxt;
      note_r  <= note_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ev_kind_r <= new_kind;
      ev_note_r <= note_r;
      ev_vel_r  <= in_midi_byte;
      ev_bend_r <= bend_raw;
    end
  end

  // lowest pending slot goes out next
  always_comb begin
    sel = '0;
    for (int i = SLOT_REGS - 1; i >= 0; i--) begin
      if (pend_r[i]) sel = SLOT_W'(i);
    end
  end

  assign sel_bit  = SLOT_REGS'(1) << sel;
  assign last_nxt = (pend_r & ~sel_bit) == '0;

  always_comb begin
    pend_nxt = pend_r;
    if (cmd.accept) pend_nxt = new_mask;
    else if (cmd.emit) pend_nxt = pend_r & ~sel_bit;
  end

  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign tr       = inst_r[sel][25:18];
  assign note_sum = {2'b00, ev_note_r} + {{2{tr[7]}}, tr};

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_slot_r <= sel;
      out_kind_r <= ev_kind_r;
      out_note_r <= (ev_kind_r == EV_PLAY || ev_kind_r == EV_STOP) ? note_sum : '0;
      out_vel_r  <= (ev_kind_r == EV_PLAY) ? ev_vel_r : '0;
      out_bend_r <= (ev_kind_r == EV_BEND) ? ev_bend_r : '0;
      out_last_r <= last_nxt;
    end
  end

  assign sts.new_nz    = new_mask != '0;
  assign sts.last_one  = last_nxt;
  assign sts.out_valid = out_valid_r;

  assign out_valid        = out_valid_r;
  assign out_slot         = out_slot_r;
  assign out_event_kind   = out_kind_r;
  assign out_note_out     = out_note_r;
  assign out_velocity_out = out_vel_r;
  assign out_bend_offset  = out_bend_r;
  assign out_last         = out_last_r;

  a_emit_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> pend_r != '0)
    else $error("event emitted with nothing pending");

  a_accept_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> pend_r == '0)
    else $error("byte taken while events still pending");

  a_first_data_silent: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && parse_r == PS_DATA1 && in_midi_byte != MIDI_CLOCK |=> pend_r == '0)
    else $error("first data byte raised events");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && last_nxt |=> pend_r == '0 && out_last)
    else $error("last event left work pending");

endmodule

// ===== rtl/core/midi_note_dispatcher.sv =====
// Channel    | Direction | Ports
// in_        | in        | in_valid, in_stall, in_midi_byte
// out_       | out       | out_valid, out_stall, out_slot, out_event_kind, out_note_out,
//            |           | out_velocity_out, out_bend_offset, out_last
// cfg_       | in        | cfg_we, cfg_index, cfg_data
//
// A byte is taken while the block is idle; each event it raises then leaves the event
// scanner in turn, and a byte raises 0 to 4 events (at most one per active slot).
// The scanner reads the four slot registers in parallel and emits the lowest pending slot.
// Reset (synchronous, rst_n low) clears the slot registers, the count and the parser.
// A stall on the output holds the scanner; the next byte is taken once all
// events sit in the output register, even while the last one waits.
module midi_note_dispatcher
  import mnd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_midi_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SLOT_W-1:0]     out_slot,
  output logic [1:0]            out_event_kind,
  output logic signed [9:0]     out_note_out,
  output logic [7:0]            out_velocity_out,
  output logic signed [15:0]    out_bend_offset,
  output logic                  out_last
);

  mnd_cmd_t cmd;
  mnd_sts_t sts;

  mnd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mnd_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_midi_byte     (in_midi_byte),
    .out_stall        (out_stall),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_slot         (out_slot),
    .out_event_kind   (out_event_kind),
    .out_note_out     (out_note_out),
    .out_velocity_out (out_velocity_out),
    .out_bend_offset  (out_bend_offset),
    .out_last         (out_last)
  );

endmodule
